### sv/mpct_pkg.sv
package mpct_pkg;

    // field widths
    localparam int BYTE_BITS  = 8;
    localparam int CFG_BITS   = 12;
    localparam int CLICK_BITS = 2;
    localparam int IDX_BITS   = 2;
    localparam int HELD_DEPTH = 3;

    // parameter defaults
    localparam int COORD_BITS_DEF       = 12;
    localparam int MAX_PACKET_BYTES_DEF = 4;

    // packet framing
    localparam int SYNC_BIT_POS = 3;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WHEEL_MODE    = 3'd0,
        CFG_SCREEN_WIDTH  = 3'd1,
        CFG_SCREEN_HEIGHT = 3'd2,
        CFG_CURSOR_WIDTH  = 3'd3,
        CFG_CURSOR_HEIGHT = 3'd4
    } cfg_index_t;

    // configuration reset values
    localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RST  = 12'd1024;
    localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RST = 12'd768;
    localparam logic [CFG_BITS-1:0] CURSOR_WIDTH_RST  = 12'd16;
    localparam logic [CFG_BITS-1:0] CURSOR_HEIGHT_RST = 12'd16;

    // click codes
    typedef enum logic [CLICK_BITS-1:0] {
        CLICK_NONE   = 2'd0,
        CLICK_LEFT   = 2'd1,
        CLICK_RIGHT  = 2'd2,
        CLICK_MIDDLE = 2'd3
    } click_t;

    // output tdata layout
    localparam int RESULT_BITS = 2 * CFG_BITS + CLICK_BITS + BYTE_BITS;
    localparam int M_DATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

endpackage

### sv/mpct_axis_clamp.sv
module mpct_axis_clamp #(
    parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]         pos,
    input  logic signed [8:0]             delta,
    input  logic [mpct_pkg::CFG_BITS-1:0] screen,
    input  logic [mpct_pkg::CFG_BITS-1:0] cursor,
    output logic [COORD_BITS-1:0]         pos_new
);

    localparam int PW    = (COORD_BITS > mpct_pkg::CFG_BITS) ? COORD_BITS : mpct_pkg::CFG_BITS;
    localparam int SUM_W = PW + 2;

    logic [mpct_pkg::CFG_BITS-1:0] limit;
    logic signed [SUM_W-1:0]       pos_ext;
    logic signed [SUM_W-1:0]       delta_ext;
    logic signed [SUM_W-1:0]       limit_ext;
    logic signed [SUM_W-1:0]       sum;
    logic signed [SUM_W-1:0]       clamped;

    // upper bound, zero when the cursor is not smaller than the screen
    assign limit = (screen > cursor) ? (screen - cursor) : '0;

    // position plus signed delta
    assign pos_ext   = $signed({{(SUM_W-COORD_BITS){1'b0}}, pos});
    assign delta_ext = $signed({{(SUM_W-9){delta[8]}}, delta});
    assign limit_ext = $signed({{(SUM_W-mpct_pkg::CFG_BITS){1'b0}}, limit});
    assign sum       = pos_ext + delta_ext;

    // clamp to [0, limit]
    always_comb
    begin
        if (sum[SUM_W-1])
            clamped = '0;
        else if (sum > limit_ext)
            clamped = limit_ext;
        else
            clamped = sum;
    end

    assign pos_new = clamped[COORD_BITS-1:0];

endmodule

### sv/mouse_packet_cursor_tracker.sv
// channel  | dir | signals                    | content
// s        | in  | s_tvalid s_tready s_tdata  | one received mouse byte
// m        | out | m_tvalid m_tready m_tdata  | cursor position, click, wheel
// cfg      | in  | cfg_we cfg_index cfg_wdata | register writes, no read-back
//
// one byte per cycle sustained while no result waits untaken; a byte passes through the
// input register and the packet result is registered in the output register
// the add and clamp of both axes are combinational from input to output register
// reset clears control, configuration and cursor state; held packet bytes are not reset
// a byte that completes a packet waits while the output register holds an untaken
// result; bytes that give no result pass on regardless
module mouse_packet_cursor_tracker #(
    parameter int COORD_BITS       = mpct_pkg::COORD_BITS_DEF,
    parameter int MAX_PACKET_BYTES = mpct_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mpct_pkg::BYTE_BITS-1:0]       s_tdata,   // rx_byte[7:0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pos_x[11:0], pos_y[23:12], click[25:24], scroll[33:26], zero fill above
    output logic [mpct_pkg::M_DATA_BITS-1:0]     m_tdata,
    input  logic                                 cfg_we,
    input  logic [mpct_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [mpct_pkg::CFG_BITS-1:0]        cfg_wdata
);

    localparam int CB = mpct_pkg::CFG_BITS;
    localparam int BB = mpct_pkg::BYTE_BITS;

    // configuration registers
    logic          wheel_mode_reg;
    logic [CB-1:0] screen_width_reg;
    logic [CB-1:0] screen_height_reg;
    logic [CB-1:0] cursor_width_reg;
    logic [CB-1:0] cursor_height_reg;

    // input register
    logic          in_valid_reg;
    logic [BB-1:0] in_byte_reg;

    // packet and cursor state
    logic [mpct_pkg::IDX_BITS-1:0] byte_index_reg;
    logic [BB-1:0]                 held_reg [mpct_pkg::HELD_DEPTH];
    logic [COORD_BITS-1:0]         cursor_x_reg;
    logic [COORD_BITS-1:0]         cursor_y_reg;

    // output register
    logic                    m_valid_reg;
    logic [CB-1:0]           out_x_reg;
    logic [CB-1:0]           out_y_reg;
    mpct_pkg::click_t        out_click_reg;
    logic [BB-1:0]           out_scroll_reg;

    logic                  size4;
    logic                  drop;
    logic                  complete;
    logic                  advance;
    logic                  out_free;
    logic [BB-1:0]         b0;
    logic [BB-1:0]         b1;
    logic [BB-1:0]         b2;
    logic [BB-1:0]         scroll_next;
    logic signed [8:0]     dx;
    logic signed [8:0]     dy;
    logic [COORD_BITS-1:0] cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_next;
    mpct_pkg::click_t      click_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_mode_reg    <= 1'b0;
            screen_width_reg  <= mpct_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= mpct_pkg::SCREEN_HEIGHT_RST;
            cursor_width_reg  <= mpct_pkg::CURSOR_WIDTH_RST;
            cursor_height_reg <= mpct_pkg::CURSOR_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mpct_pkg::CFG_WHEEL_MODE:    wheel_mode_reg    <= cfg_wdata[0];
                mpct_pkg::CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata;
                mpct_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata;
                mpct_pkg::CFG_CURSOR_WIDTH:  cursor_width_reg  <= cfg_wdata;
                mpct_pkg::CFG_CURSOR_HEIGHT: cursor_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // packet framing
    assign size4    = wheel_mode_reg && (MAX_PACKET_BYTES == 4);
    assign drop     = (byte_index_reg == '0) && !in_byte_reg[mpct_pkg::SYNC_BIT_POS];
    assign complete = !drop && (size4 ? (byte_index_reg == 2'd3) : (byte_index_reg >= 2'd2));

    // flow control
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (out_free || !complete);
    assign s_tready = !in_valid_reg || advance;

    // packet bytes
    assign b0          = held_reg[0];
    assign b1          = held_reg[1];
    assign b2          = (byte_index_reg == 2'd2) ? in_byte_reg : held_reg[2];
    assign scroll_next = size4 ? in_byte_reg : '0;

    // deltas, y inverted
    assign dx = $signed({b1[BB-1], b1});
    assign dy = -$signed({b2[BB-1], b2});

    mpct_axis_clamp #(
        .COORD_BITS (COORD_BITS)
    ) u_clamp_x (
        .pos     (cursor_x_reg),
        .delta   (dx),
        .screen  (screen_width_reg),
        .cursor  (cursor_width_reg),
        .pos_new (cursor_x_next)
    );

    mpct_axis_clamp #(
        .COORD_BITS (COORD_BITS)
    ) u_clamp_y (
        .pos     (cursor_y_reg),
        .delta   (dy),
        .screen  (screen_height_reg),
        .cursor  (cursor_height_reg),
        .pos_new (cursor_y_next)
    );

    // button priority left, right, middle
    always_comb
    begin
        if (b0[0])
            click_next = mpct_pkg::CLICK_LEFT;
        else if (b0[1])
            click_next = mpct_pkg::CLICK_RIGHT;
        else if (b0[2])
            click_next = mpct_pkg::CLICK_MIDDLE;
        else
            click_next = mpct_pkg::CLICK_NONE;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    // byte index and cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
        end
        else if (advance && !drop)
        begin
            if (complete)
            begin
                byte_index_reg <= '0;
                cursor_x_reg   <= cursor_x_next;
                cursor_y_reg   <= cursor_y_next;
            end
            else
            begin
                byte_index_reg <= byte_index_reg + 2'd1;
            end
        end
    end

    // held packet bytes
    always_ff @(posedge clk)
    begin
        if (advance && !drop && !complete && (byte_index_reg != 2'd3))
            held_reg[byte_index_reg] <= in_byte_reg;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (advance && complete)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && complete)
        begin
            out_x_reg      <= CB'(cursor_x_next);
            out_y_reg      <= CB'(cursor_y_next);
            out_click_reg  <= click_next;
            out_scroll_reg <= scroll_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(mpct_pkg::M_DATA_BITS-mpct_pkg::RESULT_BITS){1'b0}},
                       out_scroll_reg, out_click_reg, out_y_reg, out_x_reg};

    // a completed packet rewinds framing and shows a result
    a_complete_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        advance && complete |=> (byte_index_reg == '0) && m_valid_reg)
        else $error("completed packet did not rewind or show a result");

    // a dropped byte changes neither framing nor cursor
    a_drop_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && drop |=> $stable(byte_index_reg) && $stable(cursor_x_reg)
                            && $stable(cursor_y_reg))
        else $error("dropped byte changed state");

    // a held byte only stalls behind an untaken result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |-> complete && m_valid_reg && !m_tready)
        else $error("input stalled without a pending result");

    // three-byte mode never leaves the index at three after a transfer
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !size4 && !drop && !complete |=> byte_index_reg != 2'd3)
        else $error("byte index out of range in three-byte mode");

endmodule
